/* design/twtm_pkg.sv */
// package for the tick wheel timer manager
// holds sizes, command codes, sequencer states and the picker control structs
// no dependencies
package twtm_pkg;

   localparam int NUM_TIMERS  = 16;
   localparam int WHEEL_SLOTS = 8;
   localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int SLOT_W = $clog2(WHEEL_SLOTS);
   localparam int DL_W   = 33;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_START  = 2'd1,
      CMD_CANCEL = 2'd2,
      CMD_QUERY  = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIG_SCAN,
      ST_MIG_CHECK,
      ST_FIRE_SCAN,
      ST_FIRE_CHECK
   } state_type;

   typedef struct packed {
      logic              step;
      logic              first;
      logic              cand;
      logic [IDX_W-1:0]  idx;
   } pick_req_type;

   typedef struct packed {
      logic              found;
      logic [IDX_W-1:0]  idx;
   } pick_type;

endpackage

/* design/twtm_if.sv */
// request and response channel interfaces of the tick wheel timer manager
// valid/ready handshake; no dependencies
interface twtm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [3:0]  timer_id;
   logic [31:0] timeout;

   modport source (output valid, command, timer_id, timeout, input ready);
   modport sink   (input valid, command, timer_id, timeout, output ready);
endinterface

interface twtm_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        fired_valid;
   logic [3:0]  fired_id;
   logic [31:0] ticks_left;
   logic        last;

   modport source (output valid, status, fired_valid, fired_id, ticks_left, last,
                   input ready);
   modport sink   (input valid, status, fired_valid, fired_id, ticks_left, last,
                   output ready);
endinterface

/* design/twtm_picker.sv */
// oldest-timer picker: one age subtract and compare per cycle over a scan
// depends on twtm_pkg
module twtm_picker (
   input  logic                  clock,
   input  logic                  reset,
   input  twtm_pkg::pick_req_type pick_req,
   input  logic [31:0]           stamp_counter,
   input  logic [31:0]           stamp,
   output twtm_pkg::pick_type    pick
);
   import twtm_pkg::*;

   logic              found_ff, found_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [31:0]       age_ff, age_in;
   logic [31:0]       age;
   logic              have;
   logic              take;

   always_comb begin
      age      = stamp_counter - stamp;
      have     = found_ff && !pick_req.first;
      take     = pick_req.step && pick_req.cand && (!have || (age > age_ff));
      found_in = pick_req.step ? (have || pick_req.cand) : found_ff;
      idx_in   = take ? pick_req.idx : idx_ff;
      age_in   = take ? age : age_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff <= idx_in;
      age_ff <= age_in;
   end

   assign pick.found = found_ff;
   assign pick.idx   = idx_ff;

endmodule

/* design/tick_wheel_timer_manager_core.sv */
// tick wheel timer manager top level: sequencer, timer state, response register
// depends on twtm_pkg, twtm_if and twtm_picker
//
// usage
//   req channel carries one command per transaction: tick, start, cancel or query
//   rsp channel returns results; the result closing a command has last set
//   start, cancel and query are answered in the cycle after acceptance
//   a tick scans the timers with one shared age comparator: each pick of the
//   oldest matching timer is a scan pass over all timers followed by a check state
//   on a wheel turn every overflow timer costs one pass plus a final empty pass,
//   then every fired timer costs one pass plus a final empty pass
//   req ready is low while a tick is in progress or the response is stalled
//   a stalled response holds its transaction; the sequencer waits to send one
//   reset clears tick count, stamp counter and all timers; no item is pending
//   slot index is the low bits of the tick count (wheel size a power of two)
module tick_wheel_timer_manager_core (
   input  logic clock,
   input  logic reset,
   twtm_req_if.sink   req,
   twtm_rsp_if.source rsp
);
   import twtm_pkg::*;

   state_type              state_ff, state_in;
   logic [31:0]            tick_ff, tick_in;
   logic [31:0]            sc_ff, sc_in;
   logic [NUM_TIMERS-1:0]  active_ff, active_in;
   logic [NUM_TIMERS-1:0]  ovf_ff, ovf_in;
   logic [NUM_TIMERS-1:0]  seen_ff, seen_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       pend_ff, pend_in;
   logic                   have_pend_ff, have_pend_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic                   rsp_fv_ff, rsp_fv_in;
   logic [3:0]             rsp_fid_ff, rsp_fid_in;
   logic [31:0]            rsp_left_ff, rsp_left_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [DL_W-1:0]        dl_mem [NUM_TIMERS];
   logic [31:0]            st_mem [NUM_TIMERS];
   logic [IDX_W-1:0]       addr;
   logic [DL_W-1:0]        dl_rd;
   logic [31:0]            st_rd;
   logic                   dl_we, st_we;
   logic [DL_W-1:0]        dl_wdata;

   pick_req_type           pick_req;
   pick_type               pick;

   logic                   accept;
   logic                   rsp_free;
   logic [31:0]            tick_plus;
   logic [SLOT_W-1:0]      slot;
   logic                   idx_last;
   logic                   fire_go;
   logic [IDX_W-1:0]       req_idx;
   logic                   id_ok;
   logic                   bad_start;
   logic [DL_W-1:0]        dl_dec;
   logic [DL_W-1:0]        cur33;

   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept    = req.valid && req.ready;
   assign tick_plus = tick_ff + 32'd1;
   assign slot      = tick_ff[SLOT_W-1:0];
   assign idx_last  = idx_ff == IDX_W'(NUM_TIMERS - 1);
   assign req_idx   = IDX_W'(req.timer_id);
   assign id_ok     = 32'(req.timer_id) < 32'(NUM_TIMERS);
   assign bad_start = (req.timeout == 32'd0) || (req.timeout == 32'hFFFF_FFFF) || !id_ok;
   assign fire_go   = rsp_free || (pick.found && !have_pend_ff);
   assign cur33     = DL_W'(slot);
   assign dl_dec    = (dl_rd >= DL_W'(WHEEL_SLOTS)) ? dl_rd - DL_W'(WHEEL_SLOTS) : dl_rd;

   // one shared address into the deadline and stamp stores
   always_comb begin
      unique case (state_ff)
         ST_MIG_SCAN, ST_FIRE_SCAN:   addr = idx_ff;
         ST_MIG_CHECK, ST_FIRE_CHECK: addr = pick.idx;
         default:                     addr = req_idx;
      endcase
   end

   assign dl_rd = dl_mem[addr];
   assign st_rd = st_mem[addr];

   always_comb begin
      pick_req.step  = (state_ff == ST_MIG_SCAN) || (state_ff == ST_FIRE_SCAN);
      pick_req.first = idx_ff == '0;
      pick_req.idx   = idx_ff;
      if (state_ff == ST_MIG_SCAN) begin
         pick_req.cand = active_ff[idx_ff] && ovf_ff[idx_ff] && !seen_ff[idx_ff];
      end else begin
         pick_req.cand = active_ff[idx_ff] && !ovf_ff[idx_ff] && !seen_ff[idx_ff]
                         && (dl_rd == cur33);
      end
   end

   twtm_picker u_picker (
      .clock         (clock),
      .reset         (reset),
      .pick_req      (pick_req),
      .stamp_counter (sc_ff),
      .stamp         (st_rd),
      .pick          (pick)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req.command == CMD_TICK)) begin
               state_in = (tick_plus[SLOT_W-1:0] == '0) ? ST_MIG_SCAN : ST_FIRE_SCAN;
            end
         end
         ST_MIG_SCAN: begin
            if (idx_last) state_in = ST_MIG_CHECK;
         end
         ST_MIG_CHECK: begin
            state_in = pick.found ? ST_MIG_SCAN : ST_FIRE_SCAN;
         end
         ST_FIRE_SCAN: begin
            if (idx_last) state_in = ST_FIRE_CHECK;
         end
         ST_FIRE_CHECK: begin
            if (fire_go) state_in = pick.found ? ST_FIRE_SCAN : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and response control
   always_comb begin
      tick_in       = tick_ff;
      sc_in         = sc_ff;
      active_in     = active_ff;
      ovf_in        = ovf_ff;
      seen_in       = seen_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      have_pend_in  = have_pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_fv_in     = rsp_fv_ff;
      rsp_fid_in    = rsp_fid_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_last_in   = rsp_last_ff;
      dl_we         = 1'b0;
      st_we         = 1'b0;
      dl_wdata      = dl_rd;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = (req.command != CMD_TICK);
               rsp_status_in = 1'b0;
               rsp_fv_in     = 1'b0;
               rsp_fid_in    = '0;
               rsp_left_in   = '0;
               rsp_last_in   = 1'b1;
               unique case (req.command)
                  CMD_TICK: begin
                     tick_in      = tick_plus;
                     seen_in      = '0;
                     idx_in       = '0;
                     have_pend_in = 1'b0;
                  end
                  CMD_START: begin
                     rsp_status_in = bad_start;
                     if (!bad_start) begin
                        active_in[req_idx] = 1'b1;
                        dl_we = 1'b1;
                        st_we = 1'b1;
                        sc_in = sc_ff + 32'd1;
                        if (req.timeout < 32'(WHEEL_SLOTS)) begin
                           ovf_in[req_idx] = 1'b0;
                           dl_wdata = DL_W'(SLOT_W'(slot + req.timeout[SLOT_W-1:0]));
                        end else begin
                           ovf_in[req_idx] = 1'b1;
                           dl_wdata = DL_W'(req.timeout) + cur33;
                        end
                     end
                  end
                  CMD_CANCEL: begin
                     if (id_ok) begin
                        active_in[req_idx] = 1'b0;
                        ovf_in[req_idx]    = 1'b0;
                     end
                  end
                  CMD_QUERY: begin
                     if (!id_ok || !active_ff[req_idx] || (dl_rd == cur33)) begin
                        rsp_left_in = 32'hFFFF_FFFF;
                     end else if (dl_rd > cur33) begin
                        rsp_left_in = 32'(dl_rd - cur33);
                     end else begin
                        rsp_left_in = 32'(dl_rd + DL_W'(WHEEL_SLOTS) - cur33);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MIG_SCAN, ST_FIRE_SCAN: begin
            idx_in = idx_last ? '0 : idx_ff + IDX_W'(1);
         end
         ST_MIG_CHECK: begin
            if (pick.found) begin
               seen_in[pick.idx] = 1'b1;
               dl_we = 1'b1;
               dl_wdata = dl_dec;
               // lands in the wheel once under one turn away
               if (dl_dec < DL_W'(WHEEL_SLOTS)) begin
                  dl_wdata = DL_W'(SLOT_W'(slot + dl_dec[SLOT_W-1:0]));
                  ovf_in[pick.idx] = 1'b0;
                  st_we = 1'b1;
                  sc_in = sc_ff + 32'd1;
               end
            end else begin
               seen_in = '0;
            end
         end
         ST_FIRE_CHECK: begin
            if (fire_go) begin
               if (pick.found) begin
                  active_in[pick.idx] = 1'b0;
                  ovf_in[pick.idx]    = 1'b0;
                  seen_in[pick.idx]   = 1'b1;
                  pend_in             = pick.idx;
                  have_pend_in        = 1'b1;
               end else begin
                  have_pend_in = 1'b0;
               end
               // previous fired timer goes out once we know whether it is the last
               if (have_pend_ff || !pick.found) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = 1'b0;
                  rsp_fv_in     = have_pend_ff;
                  rsp_fid_in    = have_pend_ff ? 4'(pend_ff) : 4'd0;
                  rsp_left_in   = '0;
                  rsp_last_in   = !pick.found;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         sc_ff        <= '0;
         active_ff    <= '0;
         ovf_ff       <= '0;
         seen_ff      <= '0;
         idx_ff       <= '0;
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         sc_ff        <= sc_in;
         active_ff    <= active_in;
         ovf_ff       <= ovf_in;
         seen_ff      <= seen_in;
         idx_ff       <= idx_in;
         have_pend_ff <= have_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_ff       <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fv_ff     <= rsp_fv_in;
      rsp_fid_ff    <= rsp_fid_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (dl_we) dl_mem[addr] <= dl_wdata;
      if (st_we) st_mem[addr] <= sc_ff;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.fired_valid = rsp_fv_ff;
   assign rsp.fired_id    = rsp_fid_ff;
   assign rsp.ticks_left  = rsp_left_ff;
   assign rsp.last        = rsp_last_ff;

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> (state_ff == ST_IDLE))
      else $error("request taken while a tick is in progress");

   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      have_pend_ff |-> (state_ff != ST_IDLE))
      else $error("fired timer left pending in idle");

   a_pick_unseen: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FIRE_CHECK) && pick.found) |-> !seen_ff[pick.idx])
      else $error("picked a timer already visited");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.command == CMD_TICK)) |=> (state_ff != ST_IDLE))
      else $error("tick did not start a scan");
`endif

endmodule
